// ----- src/hsgh_pkg.sv -----
// Shared gear codes, register indexes and the gate decoder for the shifter hysteresis block.
package hsgh_pkg;

	// One-hot gear bits within the seven-bit engaged field.
	localparam logic [6:0] GEAR_FIRST   = 7'h01;
	localparam logic [6:0] GEAR_SECOND  = 7'h02;
	localparam logic [6:0] GEAR_THIRD   = 7'h04;
	localparam logic [6:0] GEAR_FOURTH  = 7'h08;
	localparam logic [6:0] GEAR_FIFTH   = 7'h10;
	localparam logic [6:0] GEAR_SIXTH   = 7'h20;
	localparam logic [6:0] GEAR_REVERSE = 7'h40;
	localparam logic [6:0] ROW_TOP_MASK = GEAR_FIRST | GEAR_THIRD;
	localparam logic [6:0] PAIR_MASK    = GEAR_SIXTH | GEAR_REVERSE;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_COLUMN_MAX   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CENTRE_COLUMN_MAX = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TOP_ENGAGE        = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_TOP_RELEASE       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_BOTTOM_ENGAGE     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_BOTTOM_RELEASE    = 3'd5;

	// Reset values of the thresholds.
	localparam logic [7:0] RST_LEFT_COLUMN_MAX   = 8'd96;
	localparam logic [7:0] RST_CENTRE_COLUMN_MAX = 8'd151;
	localparam logic [7:0] RST_TOP_ENGAGE        = 8'd160;
	localparam logic [7:0] RST_TOP_RELEASE       = 8'd140;
	localparam logic [7:0] RST_BOTTOM_ENGAGE     = 8'd65;
	localparam logic [7:0] RST_BOTTOM_RELEASE    = 8'd85;

	// Threshold set as one bundle.
	typedef struct packed {
		logic [7:0] left_column_max;
		logic [7:0] centre_column_max;
		logic [7:0] top_engage;
		logic [7:0] top_release;
		logic [7:0] bottom_engage;
		logic [7:0] bottom_release;
	} thresholds_t;

	// Gear picked by the stick position in a row. The right bottom gate keeps a held
	// sixth or reverse so that push-down is latched while the stick stays there.
	function automatic logic [6:0] gate_bit(input logic [7:0] x, input logic upper,
			input logic pushed, input logic [6:0] keep, input thresholds_t thr);
		logic [6:0] res;
		if (x <= thr.left_column_max) begin
			res = upper ? GEAR_FIRST : GEAR_SECOND;
		end else if (x <= thr.centre_column_max) begin
			res = upper ? GEAR_THIRD : GEAR_FOURTH;
		end else if (upper) begin
			res = '0;
		end else if ((keep & PAIR_MASK) != '0) begin
			res = keep;
		end else begin
			res = pushed ? GEAR_REVERSE : GEAR_SIXTH;
		end
		return res;
	endfunction

endpackage

// ----- src/h_shifter_gear_hysteresis.sv -----
// Top level: gear engagement with hysteresis for an H-pattern shifter report stream.
// A report accepted into the input register is decoded and moves on into the result
// register, which drives the output port.
// Throughput: one report per cycle while the receiver does not stall; the decode sits between the input register
// and the result register, with the engaged gear register fed back into the decode.
// Reset clears the pipeline valid flags and the engaged gear, and loads the
// threshold registers with their default values. The configuration port is always ready.
module h_shifter_gear_hysteresis (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] hall_x,
	input  logic [7:0] hall_y,
	input  logic       push_down,
	input  logic [7:0] gear_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] gear_out,
	output logic [6:0] engaged_now,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [hsgh_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	hsgh_pkg::thresholds_t thr_q;
	logic [6:0] engaged_q;

	logic       valid_s1;
	logic [7:0] x_s1;
	logic [7:0] y_s1;
	logic       pushed_s1;
	logic [7:0] gear_s1;

	logic       valid_s2;
	logic [7:0] gear_out_s2;
	logic [6:0] engaged_s2;

	logic       advance;
	logic [6:0] held_kept;
	logic [6:0] held_next;
	logic [7:0] gear_next;
	logic       upper;
	logic       leave_row;
	logic       conflict;

	// Handshake: the result register moves on when empty or taken; the input
	// register is stalled only while its transaction cannot move into it.
	assign advance   = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	// Threshold registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.left_column_max   <= hsgh_pkg::RST_LEFT_COLUMN_MAX;
			thr_q.centre_column_max <= hsgh_pkg::RST_CENTRE_COLUMN_MAX;
			thr_q.top_engage        <= hsgh_pkg::RST_TOP_ENGAGE;
			thr_q.top_release       <= hsgh_pkg::RST_TOP_RELEASE;
			thr_q.bottom_engage     <= hsgh_pkg::RST_BOTTOM_ENGAGE;
			thr_q.bottom_release    <= hsgh_pkg::RST_BOTTOM_RELEASE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hsgh_pkg::CFG_LEFT_COLUMN_MAX:   thr_q.left_column_max   <= cfg_data;
				hsgh_pkg::CFG_CENTRE_COLUMN_MAX: thr_q.centre_column_max <= cfg_data;
				hsgh_pkg::CFG_TOP_ENGAGE:        thr_q.top_engage        <= cfg_data;
				hsgh_pkg::CFG_TOP_RELEASE:       thr_q.top_release       <= cfg_data;
				hsgh_pkg::CFG_BOTTOM_ENGAGE:     thr_q.bottom_engage     <= cfg_data;
				hsgh_pkg::CFG_BOTTOM_RELEASE:    thr_q.bottom_release    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			x_s1      <= hall_x;
			y_s1      <= hall_y;
			pushed_s1 <= push_down;
			gear_s1   <= gear_in;
		end
	end

	// Release check on the held gear, then a fresh engage when nothing is held.
	always_comb begin
		upper     = (engaged_q & hsgh_pkg::ROW_TOP_MASK) != '0;
		leave_row = upper ? (y_s1 < thr_q.top_release) : (y_s1 > thr_q.bottom_release);
		held_kept = engaged_q;
		if (engaged_q != '0) begin
			if (leave_row
					|| hsgh_pkg::gate_bit(x_s1, upper, pushed_s1, engaged_q, thr_q) != engaged_q)
			begin
				held_kept = '0;
			end
		end
		held_next = held_kept;
		if (held_kept == '0) begin
			if (y_s1 >= thr_q.top_engage) begin
				held_next = hsgh_pkg::gate_bit(x_s1, 1'b1, pushed_s1, '0, thr_q);
			end else if (y_s1 <= thr_q.bottom_engage) begin
				held_next = hsgh_pkg::gate_bit(x_s1, 1'b0, pushed_s1, '0, thr_q);
			end
		end
	end

	// Merge into the gear byte unless the firmware already reports the other
	// gear of the sixth and reverse pair.
	always_comb begin
		conflict  = ((held_next & hsgh_pkg::PAIR_MASK) != '0)
			&& ((gear_s1[6:0] & hsgh_pkg::PAIR_MASK & ~held_next) != '0);
		gear_next = conflict ? gear_s1 : (gear_s1 | {1'b0, held_next});
	end

	// Engaged gear and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			engaged_q <= '0;
			valid_s2  <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				engaged_q <= held_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			gear_out_s2 <= gear_next;
			engaged_s2  <= held_next;
		end
	end

	assign out_valid   = valid_s2;
	assign gear_out    = gear_out_s2;
	assign engaged_now = engaged_s2;

	// At most one gear is held, and the fifth gate never engages.
	a_engaged_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(engaged_q) && ((engaged_q & hsgh_pkg::GEAR_FIFTH) == '0))
		else $error("engaged gear is not one-hot or holds the fifth gate");

	// The shown result always reflects the current engaged state.
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (engaged_s2 == engaged_q))
		else $error("result engaged gear differs from the held state");

	// A stall towards the input only arises from a waiting transaction.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a blocked transaction");

	// The held gear changes only when a transaction moves into the result register.
	a_state_moves_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && valid_s1) |=> $stable(engaged_q))
		else $error("engaged gear changed without a transaction");

endmodule

// ----- bench/tb_h_shifter_gear_hysteresis.sv -----
// Self-checking testbench for the H-pattern shifter gear hysteresis block.
`timescale 1ns / 1ps

module tb_h_shifter_gear_hysteresis;

	localparam int RANDOM_PER_PHASE = 166;
	localparam int PHASES           = 8;
	localparam int HOLD_OFF_CYCLES  = 64;
	localparam int IDLE_LIMIT       = 2000;
	localparam int DIRECTED_ROWS    = 20;

	// Indexes beyond the last threshold register; the block must ignore them.
	localparam logic [hsgh_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [hsgh_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

	// Result of one report: the patched gear byte and the gear now held.
	typedef struct packed {
		logic [7:0] gear;
		logic [6:0] eng;
	} shift_result_t;

	// One directed report, with the result typed in where it is obvious.
	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic       pd;
		logic [7:0] gear;
		logic       known;
		logic [7:0] want_gear;
		logic [6:0] want_eng;
	} report_row_t;

	localparam report_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
		// Top left engages first, holds above release, drops just below it.
		'{8'd0,   8'd255, 1'b0, 8'h00, 1'b1,
			{1'b0, hsgh_pkg::GEAR_FIRST}, hsgh_pkg::GEAR_FIRST},
		'{8'd0,   8'd141, 1'b0, 8'h00, 1'b1,
			{1'b0, hsgh_pkg::GEAR_FIRST}, hsgh_pkg::GEAR_FIRST},
		'{8'd0,   8'd139, 1'b0, 8'h00, 1'b1, 8'h00, 7'h00},
		// Bottom left, held on the column edge, lost one step to the right.
		'{8'd0,   8'd0,   1'b0, 8'h00, 1'b1,
			{1'b0, hsgh_pkg::GEAR_SECOND}, hsgh_pkg::GEAR_SECOND},
		'{8'd96,  8'd85,  1'b0, 8'h00, 1'b1,
			{1'b0, hsgh_pkg::GEAR_SECOND}, hsgh_pkg::GEAR_SECOND},
		'{8'd97,  8'd85,  1'b0, 8'h00, 1'b1, 8'h00, 7'h00},
		// Centre column, then straight across from third to fourth.
		'{8'd151, 8'd160, 1'b0, 8'h00, 1'b1,
			{1'b0, hsgh_pkg::GEAR_THIRD}, hsgh_pkg::GEAR_THIRD},
		'{8'd151, 8'd65,  1'b0, 8'h00, 1'b1,
			{1'b0, hsgh_pkg::GEAR_FOURTH}, hsgh_pkg::GEAR_FOURTH},
		// The fifth gate engages nothing; the firmware bit passes through.
		'{8'd152, 8'd255, 1'b0, {1'b0, hsgh_pkg::GEAR_FIFTH}, 1'b1,
			{1'b0, hsgh_pkg::GEAR_FIFTH}, 7'h00},
		// Reverse latched against push-down, and the sixth/reverse conflict.
		'{8'd255, 8'd0,   1'b1, 8'h00, 1'b1,
			{1'b0, hsgh_pkg::GEAR_REVERSE}, hsgh_pkg::GEAR_REVERSE},
		'{8'd255, 8'd30,  1'b0, 8'h00, 1'b1,
			{1'b0, hsgh_pkg::GEAR_REVERSE}, hsgh_pkg::GEAR_REVERSE},
		'{8'd255, 8'd30,  1'b0, {1'b0, hsgh_pkg::GEAR_SIXTH}, 1'b1,
			{1'b0, hsgh_pkg::GEAR_SIXTH}, hsgh_pkg::GEAR_REVERSE},
		'{8'd200, 8'd85,  1'b0, 8'hFF, 1'b1, 8'hFF, hsgh_pkg::GEAR_REVERSE},
		'{8'd255, 8'd86,  1'b0, 8'h00, 1'b1, 8'h00, 7'h00},
		'{8'd255, 8'd0,   1'b0, {1'b0, hsgh_pkg::GEAR_REVERSE}, 1'b1,
			{1'b0, hsgh_pkg::GEAR_REVERSE}, hsgh_pkg::GEAR_SIXTH},
		// The remainder are left to the predictor.
		'{8'd255, 8'd0,   1'b1, 8'h80, 1'b0, 8'h00, 7'h00},
		'{8'd50,  8'd0,   1'b0, 8'h7F, 1'b0, 8'h00, 7'h00},
		'{8'd255, 8'd255, 1'b0, {1'b0, hsgh_pkg::GEAR_SIXTH}, 1'b0, 8'h00, 7'h00},
		'{8'd120, 8'd255, 1'b1, 8'h55, 1'b0, 8'h00, 7'h00},
		'{8'd120, 8'd140, 1'b0, 8'hAA, 1'b0, 8'h00, 7'h00}
	};

	// Thresholds whose engage conditions overlap, so both rows qualify at once.
	localparam hsgh_pkg::thresholds_t CROSSED_SET =
		'{8'd200, 8'd50, 8'd30, 8'd250, 8'd220, 8'd10};
	localparam hsgh_pkg::thresholds_t DEFAULT_SET = '{
		hsgh_pkg::RST_LEFT_COLUMN_MAX, hsgh_pkg::RST_CENTRE_COLUMN_MAX,
		hsgh_pkg::RST_TOP_ENGAGE, hsgh_pkg::RST_TOP_RELEASE,
		hsgh_pkg::RST_BOTTOM_ENGAGE, hsgh_pkg::RST_BOTTOM_RELEASE};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] hall_x;
	logic [7:0] hall_y;
	logic push_down;
	logic [7:0] gear_in;
	logic out_valid;
	logic out_stall;
	logic [7:0] gear_out;
	logic [6:0] engaged_now;
	logic cfg_valid;
	logic cfg_ready;
	logic [hsgh_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [7:0] cfg_data;

	hsgh_pkg::thresholds_t thr;
	logic [6:0] held_gear;
	shift_result_t pending_gears [$];
	int mismatches;
	int idle_cycles;
	logic steady;
	logic hold_off_req;
	logic [7:0] stick_x;
	int stick_run;

	h_shifter_gear_hysteresis dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.hall_x(hall_x),
		.hall_y(hall_y),
		.push_down(push_down),
		.gear_in(gear_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.gear_out(gear_out),
		.engaged_now(engaged_now),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Free-running 2 ns clock.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Gear selected by the stick in one row, keeping a held sixth or reverse.
	function automatic logic [6:0] gate_for_stick(input logic [7:0] x, input logic upper,
			input logic pd, input logic [6:0] keep);
		if (x <= thr.left_column_max)
			return upper ? hsgh_pkg::GEAR_FIRST : hsgh_pkg::GEAR_SECOND;
		if (x <= thr.centre_column_max)
			return upper ? hsgh_pkg::GEAR_THIRD : hsgh_pkg::GEAR_FOURTH;
		if (upper)
			return 7'h00;
		if ((keep & hsgh_pkg::PAIR_MASK) != 7'h00)
			return keep;
		return pd ? hsgh_pkg::GEAR_REVERSE : hsgh_pkg::GEAR_SIXTH;
	endfunction

	// Expected result of one report given the gear currently held.
	function automatic shift_result_t decode_report(input logic [7:0] x, input logic [7:0] y,
			input logic pd, input logic [7:0] gear);
		shift_result_t r;
		logic [6:0] h;
		logic upper;
		logic gone;
		h = held_gear;
		if (h != 7'h00) begin
			upper = (h & hsgh_pkg::ROW_TOP_MASK) != 7'h00;
			gone = upper ? (y < thr.top_release) : (y > thr.bottom_release);
			if (gone || gate_for_stick(x, upper, pd, h) != h)
				h = 7'h00;
		end
		if (h == 7'h00) begin
			if (y >= thr.top_engage)
				h = gate_for_stick(x, 1'b1, pd, 7'h00);
			else if (y <= thr.bottom_engage)
				h = gate_for_stick(x, 1'b0, pd, 7'h00);
		end
		// The bit is not added when the firmware already reports the other pair gear.
		if ((h & hsgh_pkg::PAIR_MASK) != 7'h00
				&& (gear[6:0] & hsgh_pkg::PAIR_MASK & ~h) != 7'h00)
			r.gear = gear;
		else
			r.gear = gear | {1'b0, h};
		r.eng = h;
		return r;
	endfunction

	// Random value close to a threshold, or anywhere.
	function automatic logic [7:0] jitter_around(input logic [7:0] v);
		case ($urandom_range(0, 3))
			0: return v - 8'd1;
			1: return v;
			2: return v + 8'd1;
			default: return 8'($urandom);
		endcase
	endfunction

	// Idle cycles before the next report: mostly none, sometimes a few, rarely many.
	function automatic int sender_gap();
		if (steady || $urandom_range(0, 3) != 0)
			return 0;
		return ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 30))
			: int'($urandom_range(1, 3));
	endfunction

	// Offer one report and record its expected result once it is accepted.
	task automatic offer_report(input logic [7:0] x, input logic [7:0] y, input logic pd,
			input logic [7:0] gear, input logic known, input logic [7:0] want_gear,
			input logic [6:0] want_eng);
		int gap;
		shift_result_t r;
		gap = sender_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		hall_x = x;
		hall_y = y;
		push_down = pd;
		gear_in = gear;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		r = decode_report(x, y, pd, gear);
		held_gear = r.eng;
		if (known) begin
			r.gear = want_gear;
			r.eng = want_eng;
		end
		pending_gears.push_back(r);
	endtask

	// Stick movement: a column held for a short run while Y wanders about the thresholds.
	task automatic offer_random_report();
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] gear;
		if (stick_run == 0) begin
			stick_run = $urandom_range(2, 8);
			case ($urandom_range(0, 2))
				0: stick_x = jitter_around(thr.left_column_max);
				1: stick_x = jitter_around(thr.centre_column_max);
				default: stick_x = 8'($urandom);
			endcase
		end
		stick_run--;
		x = ($urandom_range(0, 7) == 0) ? 8'($urandom) : stick_x;
		case ($urandom_range(0, 6))
			0: y = jitter_around(thr.top_engage);
			1: y = jitter_around(thr.top_release);
			2: y = jitter_around(thr.bottom_engage);
			3: y = jitter_around(thr.bottom_release);
			4: y = 8'd0;
			5: y = 8'd255;
			default: y = 8'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: gear = 8'h00;
			1: gear = 8'h01 << $urandom_range(0, 7);
			2: gear = {1'b0, 2'($urandom), 5'h00};
			default: gear = 8'($urandom);
		endcase
		offer_report(x, y, 1'($urandom), gear, 1'b0, 8'h00, 7'h00);
	endtask

	// Register write; the valid stays high for a following write.
	task automatic write_reg(input logic [hsgh_pkg::CFG_INDEX_W-1:0] idx,
			input logic [7:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			hsgh_pkg::CFG_LEFT_COLUMN_MAX:   thr.left_column_max = val;
			hsgh_pkg::CFG_CENTRE_COLUMN_MAX: thr.centre_column_max = val;
			hsgh_pkg::CFG_TOP_ENGAGE:        thr.top_engage = val;
			hsgh_pkg::CFG_TOP_RELEASE:       thr.top_release = val;
			hsgh_pkg::CFG_BOTTOM_ENGAGE:     thr.bottom_engage = val;
			hsgh_pkg::CFG_BOTTOM_RELEASE:    thr.bottom_release = val;
			default: ;
		endcase
	endtask

	task automatic load_thresholds(input hsgh_pkg::thresholds_t t);
		write_reg(hsgh_pkg::CFG_LEFT_COLUMN_MAX, t.left_column_max);
		write_reg(hsgh_pkg::CFG_CENTRE_COLUMN_MAX, t.centre_column_max);
		write_reg(hsgh_pkg::CFG_TOP_ENGAGE, t.top_engage);
		write_reg(hsgh_pkg::CFG_TOP_RELEASE, t.top_release);
		write_reg(hsgh_pkg::CFG_BOTTOM_ENGAGE, t.bottom_engage);
		write_reg(hsgh_pkg::CFG_BOTTOM_RELEASE, t.bottom_release);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Stop offering and wait until every expected result has come out.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_gears.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Receiver: random stalls, occasional long bursts, and one long hold-off on request.
	initial begin
		int burst;
		burst = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall = 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				out_stall = 1'b0;
			end else if (burst > 0) begin
				out_stall = 1'b1;
				burst--;
			end else if (!steady && $urandom_range(0, 4) == 0) begin
				out_stall = 1'b1;
				burst = ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 30))
					: int'($urandom_range(0, 2));
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// Each result transaction is compared with the oldest expectation.
	always @(posedge clk) begin
		shift_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_gears.size() == 0) begin
				$error("unexpected result: gear_out %h engaged_now %h", gear_out, engaged_now);
				mismatches++;
			end else begin
				exp_r = pending_gears.pop_front();
				if (gear_out !== exp_r.gear) begin
					$error("gear_out: expected %h, got %h", exp_r.gear, gear_out);
					mismatches++;
				end
				if (engaged_now !== exp_r.eng) begin
					$error("engaged_now: expected %h, got %h", exp_r.eng, engaged_now);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_h_shifter_gear_hysteresis: FAIL");
			$finish;
		end
	end

	// Main sequence: directed reports at reset settings, then phases of random reports.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		hall_x = 8'h00;
		hall_y = 8'h00;
		push_down = 1'b0;
		gear_in = 8'h00;
		cfg_valid = 1'b0;
		cfg_index = hsgh_pkg::CFG_LEFT_COLUMN_MAX;
		cfg_data = 8'h00;
		mismatches = 0;
		idle_cycles = 0;
		steady = 1'b0;
		hold_off_req = 1'b0;
		stick_x = 8'h00;
		stick_run = 0;
		thr = DEFAULT_SET;
		held_gear = 7'h00;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				for (int i = 0; i < DIRECTED_ROWS; i++)
					offer_report(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].pd, DIRECTED[i].gear,
						DIRECTED[i].known, DIRECTED[i].want_gear, DIRECTED[i].want_eng);
			end else begin
				drain();
				if (p == 4) begin
					write_reg(CFG_SPARE_LO, 8'($urandom));
					write_reg(CFG_SPARE_HI, 8'($urandom));
				end
				case (p)
					1: load_thresholds('0);
					2: load_thresholds('1);
					3: load_thresholds(CROSSED_SET);
					6: load_thresholds(DEFAULT_SET);
					default: load_thresholds(hsgh_pkg::thresholds_t'({16'($urandom), $urandom}));
				endcase
			end
			// Long receiver hold-off while reports keep coming, to back the block up.
			if (p == 1)
				hold_off_req = 1'b1;
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				if (i % 40 == 0)
					steady = ($urandom_range(0, 3) == 0);
				offer_random_report();
			end
		end

		steady = 1'b0;
		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && pending_gears.size() == 0)
			$display("tb_h_shifter_gear_hysteresis: PASS");
		else
			$display("tb_h_shifter_gear_hysteresis: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/hsgh_pkg.sv
src/h_shifter_gear_hysteresis.sv
bench/tb_h_shifter_gear_hysteresis.sv
